// ----- design/quadratic_root_solver_assert.svh -----
// assertion macros used by the checker file
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// condition implies a property in the same cycle
`define QRS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qrs check failed");

// condition implies a property in the next cycle
`define QRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrs check failed");

`endif

// ----- design/qrs_pkg.sv -----
// ----------------------------------------------------------------------------
// qrs_pkg
// Types, widths and arithmetic steps shared by the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    // field widths
    localparam int COEF_W   = 16;
    localparam int ROOT_W   = 32;
    localparam int FRAC_OUT = 16;

    // internal widths
    localparam int PROD_W   = 2 * COEF_W;
    localparam int DISC_W   = 2 * COEF_W + 1;
    localparam int SQ_STEPS = (DISC_W + 2 * FRAC_OUT + 1) / 2;
    localparam int SQX_W    = 2 * SQ_STEPS;
    localparam int SQR_W    = SQ_STEPS + 2;
    localparam int NUM_W    = COEF_W + FRAC_OUT + 1;
    localparam int DEN_W    = COEF_W + 2;
    localparam int DM_W     = COEF_W + 1;
    localparam int NX_W     = SQ_STEPS + 2;
    localparam int NM_W     = NX_W - 1;

    // queue between front and back
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = Q_PTR_W + 1;

    // saturation limits
    localparam logic signed [ROOT_W-1:0] ROOT_MAX = {1'b0, {(ROOT_W-1){1'b1}}};
    localparam logic signed [ROOT_W-1:0] ROOT_MIN = {1'b1, {(ROOT_W-1){1'b0}}};

    typedef enum logic [2:0] {
        KIND_INF  = 3'd0,
        KIND_NONE = 3'd1,
        KIND_LIN  = 3'd2,
        KIND_DBL  = 3'd3,
        KIND_TWO  = 3'd4
    } kind_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } coef_t;

    typedef struct packed {
        kind_t                    kind;
        logic signed [ROOT_W-1:0] root_one;
        logic signed [ROOT_W-1:0] root_two;
        logic                     overflow;
    } root_t;

    // classified item handed from front to back
    typedef struct packed {
        kind_t                   kind;
        logic signed [NUM_W-1:0] num;
        logic signed [DEN_W-1:0] den;
        logic [DISC_W-1:0]       disc;
    } job_t;

    // square root working state
    typedef struct packed {
        logic [SQX_W-1:0]    x;
        logic [SQR_W-1:0]    rem;
        logic [SQ_STEPS-1:0] root;
    } sq_t;

    // divider working state
    typedef struct packed {
        logic [DM_W-1:0] rem;
        logic [NM_W-1:0] nq;
    } dv_t;

    // one root bit: bring in two radicand bits, try the next bit
    function automatic sq_t sqrt_step(input sq_t s);
        sq_t              r;
        logic [SQR_W-1:0] cur;
        logic [SQR_W-1:0] trial;
        cur   = {s.rem[SQ_STEPS-1:0], s.x[SQX_W-1 -: 2]};
        trial = {s.root, 2'b01};
        r.x   = {s.x[SQX_W-3:0], 2'b00};
        if (cur >= trial)
        begin
            r.rem  = cur - trial;
            r.root = {s.root[SQ_STEPS-2:0], 1'b1};
        end
        else
        begin
            r.rem  = cur;
            r.root = {s.root[SQ_STEPS-2:0], 1'b0};
        end
        return r;
    endfunction

    // one quotient bit of a restoring division
    function automatic dv_t div_step(input dv_t s, input logic [DM_W-1:0] den);
        dv_t           r;
        logic [DM_W:0] cur;
        cur  = {s.rem, s.nq[NM_W-1]};
        r.nq = {s.nq[NM_W-2:0], 1'b0};
        if (cur >= {1'b0, den})
        begin
            cur     = cur - {1'b0, den};
            r.nq[0] = 1'b1;
        end
        r.rem = cur[DM_W-1:0];
        return r;
    endfunction

    // clamp a signed magnitude to the root range, overflow flag on top
    function automatic logic [ROOT_W:0] sat_root(input logic [NM_W-1:0] q, input logic neg);
        logic [NM_W-1:0]   max_pos;
        logic [ROOT_W-1:0] v;
        logic              ovf;
        max_pos = {{(NM_W-ROOT_W+1){1'b0}}, {(ROOT_W-1){1'b1}}};
        ovf     = 1'b0;
        if (neg)
        begin
            if (q > max_pos + NM_W'(1))
            begin
                ovf = 1'b1;
                v   = ROOT_MIN;
            end
            else
            begin
                v = ROOT_W'(0) - q[ROOT_W-1:0];
            end
        end
        else
        begin
            if (q > max_pos)
            begin
                ovf = 1'b1;
                v   = ROOT_MAX;
            end
            else
            begin
                v = q[ROOT_W-1:0];
            end
        end
        return {ovf, v};
    endfunction

endpackage

// ----- design/qrs_front.sv -----
// ----------------------------------------------------------------------------
// qrs_front
// Takes coefficient transfers, forms the discriminant and classifies them.
// ----------------------------------------------------------------------------
module qrs_front
    import qrs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  coef_valid,
    output logic  coef_stall,
    input  coef_t coefs,
    input  logic  q_full,
    output logic  push,
    output job_t  job
);

    logic                     s1_valid_reg;
    coef_t                    s1_reg;
    logic                     s2_valid_reg;
    coef_t                    s2_reg;
    logic signed [PROD_W-1:0] bsq_reg;
    logic signed [PROD_W-1:0] ac_reg;
    logic signed [PROD_W-1:0] bsq_next;
    logic signed [PROD_W-1:0] ac_next;
    logic signed [DISC_W:0]   disc;
    logic signed [NUM_W-1:0]  ext_b;
    logic signed [NUM_W-1:0]  ext_c;
    logic                     fe_en;

    // front advances unless the last stage is blocked by a full queue
    assign fe_en      = !(s2_valid_reg && q_full);
    assign coef_stall = !fe_en;
    assign push       = fe_en && s2_valid_reg;

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (fe_en)
        begin
            s1_valid_reg <= coef_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // products of the discriminant
    assign bsq_next = s1_reg.coef_b * s1_reg.coef_b;
    assign ac_next  = s1_reg.coef_a * s1_reg.coef_c;

    // stage payload
    always_ff @(posedge clk)
    begin
        if (fe_en)
        begin
            s1_reg  <= coefs;
            s2_reg  <= s1_reg;
            bsq_reg <= bsq_next;
            ac_reg  <= ac_next;
        end
    end

    // b*b - 4*a*c, exact
    assign disc = $signed({{2{bsq_reg[PROD_W-1]}}, bsq_reg})
                - $signed({ac_reg, 2'b00});

    // coefficients moved to the root scale
    assign ext_b = {s2_reg.coef_b[COEF_W-1], s2_reg.coef_b, {FRAC_OUT{1'b0}}};
    assign ext_c = {s2_reg.coef_c[COEF_W-1], s2_reg.coef_c, {FRAC_OUT{1'b0}}};

    // classification
    always_comb
    begin
        job = '0;
        priority if (s2_reg.coef_a == '0)
        begin
            if (s2_reg.coef_b == '0)
            begin
                job.kind = (s2_reg.coef_c == '0) ? KIND_INF : KIND_NONE;
            end
            else
            begin
                job.kind = KIND_LIN;
                job.num  = -ext_c;
                job.den  = {{2{s2_reg.coef_b[COEF_W-1]}}, s2_reg.coef_b};
            end
        end
        else if (disc < 0)
        begin
            job.kind = KIND_NONE;
        end
        else
        begin
            job.kind = (disc == '0) ? KIND_DBL : KIND_TWO;
            job.num  = -ext_b;
            job.den  = {s2_reg.coef_a[COEF_W-1], s2_reg.coef_a, 1'b0};
            job.disc = disc[DISC_W-1:0];
        end
    end

endmodule

// ----- design/qrs_queue.sv -----
// ----------------------------------------------------------------------------
// qrs_queue
// Small first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module qrs_queue
    import qrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wdata,
    output logic full,
    input  logic pop,
    output logic nempty,
    output job_t rdata
);

    job_t                 mem_reg [0:Q_DEPTH-1];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   cnt_reg;
    logic [Q_CNT_W-1:0]   cnt_next;

    assign full     = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign nempty   = (cnt_reg != '0);
    assign rdata    = mem_reg[rd_ptr_reg];
    assign cnt_next = cnt_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- design/qrs_sqrt.sv -----
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root of the scaled discriminant, one bit a stage.
// ----------------------------------------------------------------------------
module qrs_sqrt
    import qrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  job_t                in_job,
    output logic                out_valid,
    output job_t                out_job,
    output logic [SQ_STEPS-1:0] out_root
);

    logic valid_reg [0:SQ_STEPS];
    job_t job_reg   [0:SQ_STEPS];
    sq_t  sq_reg    [0:SQ_STEPS];
    sq_t  sq_load;

    // radicand is the discriminant with sixteen extra fraction bits of root
    assign sq_load.x    = SQX_W'({in_job.disc, {(2*FRAC_OUT){1'b0}}});
    assign sq_load.rem  = '0;
    assign sq_load.root = '0;

    // entry stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            job_reg[0] <= in_job;
            sq_reg[0]  <= sq_load;
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                job_reg[k+1] <= job_reg[k];
                sq_reg[k+1]  <= sqrt_step(sq_reg[k]);
            end
        end
    end

    assign out_valid = valid_reg[SQ_STEPS];
    assign out_job   = job_reg[SQ_STEPS];
    assign out_root  = sq_reg[SQ_STEPS].root;

endmodule

// ----- design/qrs_div.sv -----
// ----------------------------------------------------------------------------
// qrs_div
// Two-lane pipelined restoring divider sharing one divisor, truncating.
// ----------------------------------------------------------------------------
module qrs_div
    import qrs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  kind_t                  in_kind,
    input  logic signed [NX_W-1:0] in_num1,
    input  logic signed [NX_W-1:0] in_num2,
    input  logic signed [DEN_W-1:0] in_den,
    output logic                   out_valid,
    output kind_t                  out_kind,
    output logic [NM_W-1:0]        out_q1,
    output logic                   out_neg1,
    output logic [NM_W-1:0]        out_q2,
    output logic                   out_neg2
);

    logic            valid_reg [0:NM_W];
    kind_t           kind_reg  [0:NM_W];
    logic [DM_W-1:0] den_reg   [0:NM_W];
    logic            neg1_reg  [0:NM_W];
    logic            neg2_reg  [0:NM_W];
    dv_t             dv1_reg   [0:NM_W];
    dv_t             dv2_reg   [0:NM_W];
    logic [NX_W-1:0]  n1_abs;
    logic [NX_W-1:0]  n2_abs;
    logic [DEN_W-1:0] d_abs;

    // magnitudes and quotient signs
    assign n1_abs = in_num1[NX_W-1] ? NX_W'(-in_num1) : NX_W'(in_num1);
    assign n2_abs = in_num2[NX_W-1] ? NX_W'(-in_num2) : NX_W'(in_num2);
    assign d_abs  = in_den[DEN_W-1] ? DEN_W'(-in_den) : DEN_W'(in_den);

    // entry stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg[0]   <= in_kind;
            den_reg[0]    <= d_abs[DM_W-1:0];
            neg1_reg[0]   <= in_num1[NX_W-1] ^ in_den[DEN_W-1];
            neg2_reg[0]   <= in_num2[NX_W-1] ^ in_den[DEN_W-1];
            dv1_reg[0]    <= '{rem: '0, nq: n1_abs[NM_W-1:0]};
            dv2_reg[0]    <= '{rem: '0, nq: n2_abs[NM_W-1:0]};
        end
    end

    // one quotient bit per stage in each lane
    for (genvar k = 0; k < NM_W; k++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                kind_reg[k+1] <= kind_reg[k];
                den_reg[k+1]  <= den_reg[k];
                neg1_reg[k+1] <= neg1_reg[k];
                neg2_reg[k+1] <= neg2_reg[k];
                dv1_reg[k+1]  <= div_step(dv1_reg[k], den_reg[k]);
                dv2_reg[k+1]  <= div_step(dv2_reg[k], den_reg[k]);
            end
        end
    end

    assign out_valid = valid_reg[NM_W];
    assign out_kind  = kind_reg[NM_W];
    assign out_q1    = dv1_reg[NM_W].nq;
    assign out_neg1  = neg1_reg[NM_W];
    assign out_q2    = dv2_reg[NM_W].nq;
    assign out_neg2  = neg2_reg[NM_W];

endmodule

// ----- design/qrs_back.sv -----
// ----------------------------------------------------------------------------
// qrs_back
// Square root, division and saturation of queued items, output register.
// ----------------------------------------------------------------------------
module qrs_back
    import qrs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_nempty,
    input  job_t  q_job,
    output logic  pop,
    output logic  res_valid,
    input  logic  res_stall,
    output root_t res
);

    logic                    en;
    logic                    sq_valid;
    job_t                    sq_job;
    logic [SQ_STEPS-1:0]     sq_root;
    logic signed [NX_W-1:0]  num_ext;
    logic signed [NX_W-1:0]  root_ext;
    logic signed [NX_W-1:0]  n1;
    logic signed [NX_W-1:0]  n2;
    logic                    dv_valid;
    kind_t                   dv_kind;
    logic [NM_W-1:0]         q1;
    logic [NM_W-1:0]         q2;
    logic                    neg1;
    logic                    neg2;
    logic [ROOT_W:0]         sat1;
    logic [ROOT_W:0]         sat2;
    logic                    res_valid_reg;
    root_t                   res_reg;
    root_t                   res_next;

    // whole back pipeline moves when the output register can take a result
    assign en  = !res_valid_reg || !res_stall;
    assign pop = en && q_nempty;

    qrs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_nempty),
        .in_job    (q_job),
        .out_valid (sq_valid),
        .out_job   (sq_job),
        .out_root  (sq_root)
    );

    // numerators -b +/- sqrt(d), or the single numerator
    assign num_ext  = {{(NX_W-NUM_W){sq_job.num[NUM_W-1]}}, sq_job.num};
    assign root_ext = {{(NX_W-SQ_STEPS){1'b0}}, sq_root};
    assign n1       = (sq_job.kind == KIND_TWO) ? num_ext + root_ext : num_ext;
    assign n2       = (sq_job.kind == KIND_TWO) ? num_ext - root_ext : num_ext;

    qrs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_kind   (sq_job.kind),
        .in_num1   (n1),
        .in_num2   (n2),
        .in_den    (sq_job.den),
        .out_valid (dv_valid),
        .out_kind  (dv_kind),
        .out_q1    (q1),
        .out_neg1  (neg1),
        .out_q2    (q2),
        .out_neg2  (neg2)
    );

    // saturation and result assembly
    assign sat1 = sat_root(q1, neg1);
    assign sat2 = sat_root(q2, neg2);

    always_comb
    begin
        res_next      = '0;
        res_next.kind = dv_kind;
        unique case (dv_kind)
            KIND_INF, KIND_NONE:
            begin
                res_next.root_one = '0;
                res_next.root_two = '0;
                res_next.overflow = 1'b0;
            end
            KIND_LIN, KIND_DBL:
            begin
                res_next.root_one = sat1[ROOT_W-1:0];
                res_next.root_two = sat1[ROOT_W-1:0];
                res_next.overflow = sat1[ROOT_W];
            end
            KIND_TWO:
            begin
                res_next.root_one = sat1[ROOT_W-1:0];
                res_next.root_two = sat2[ROOT_W-1:0];
                res_next.overflow = sat1[ROOT_W] | sat2[ROOT_W];
            end
            default:
            begin
                res_next.root_one = '0;
                res_next.root_two = '0;
                res_next.overflow = 1'b0;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- design/quadratic_root_solver.sv -----
// throughput: one item per cycle while no result is stalled, held by a one-bit-per-stage
// square root pipeline (33 stages) and a two-lane divider pipeline (34 stages)
// a four-entry queue lets the front keep taking items while a result is stalled
// reset: asynchronous, active low; clears all stage valids and empties the queue
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 for signed Q8.8 coefficients, in Q16.16.
// ----------------------------------------------------------------------------
module quadratic_root_solver
    import qrs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  coef_valid,
    output logic  coef_stall,
    input  coef_t coefs,
    output logic  res_valid,
    input  logic  res_stall,
    output root_t res
);

    logic q_full;
    logic q_push;
    job_t q_wdata;
    logic q_pop;
    logic q_nempty;
    job_t q_rdata;

    // classify
    qrs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_valid (coef_valid),
        .coef_stall (coef_stall),
        .coefs      (coefs),
        .q_full     (q_full),
        .push       (q_push),
        .job        (q_wdata)
    );

    // decouple
    qrs_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .full   (q_full),
        .pop    (q_pop),
        .nempty (q_nempty),
        .rdata  (q_rdata)
    );

    // solve
    qrs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_nempty  (q_nempty),
        .q_job     (q_rdata),
        .pop       (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

// ----- design/qrs_checker.sv -----
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks on result transfers of the quadratic root solver.
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_assert.svh"

module qrs_checker
    import qrs_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  res_valid,
    input logic  res_stall,
    input root_t res
);

    // a stalled result stays offered unchanged
    `QRS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

    // no roots means zero fields and no overflow
    `QRS_ASSERT_NOW(a_no_root, res_valid && (res.kind == KIND_INF || res.kind == KIND_NONE), res.root_one == 0 && res.root_two == 0 && !res.overflow)

    // single-root kinds repeat the root
    `QRS_ASSERT_NOW(a_single_root, res_valid && (res.kind == KIND_LIN || res.kind == KIND_DBL), res.root_two == res.root_one)

    // overflow only with a root clamped to a range end
    `QRS_ASSERT_NOW(a_sat_end, res_valid && res.overflow, res.root_one == ROOT_MAX || res.root_one == ROOT_MIN || res.root_two == ROOT_MAX || res.root_two == ROOT_MIN)

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

// ----- dv/quadratic_root_solver_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_test
// Drives coefficient triples through the solver under several idle and stall
// mixes, predicts each root result in the bench and compares field by field.
// ----------------------------------------------------------------------------
module quadratic_root_solver_test;
    import qrs_pkg::*;

    logic  clk;
    logic  rst_n;
    logic  coef_valid;
    logic  coef_stall;
    coef_t coefs;
    logic  res_valid;
    logic  res_stall;
    root_t res;

    root_t expected_roots[$];
    int    error_count;
    int    send_idle_pct;
    int    recv_stall_pct;
    int    quiet_cycles;

    quadratic_root_solver DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .coef_valid(coef_valid),
        .coef_stall(coef_stall),
        .coefs(coefs),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // saturate a wide signed quotient to the root range
    function automatic logic [31:0] clamp_root(input logic signed [127:0] v,
                                                inout logic ovf);
        if (v > 128'sd2147483647)
        begin
            ovf = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -128'sd2147483648)
        begin
            ovf = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // root prediction from one coefficient triple
    function automatic root_t solve_roots(input coef_t c);
        root_t                 r;
        logic signed [127:0]   a, b, k, disc, nb, s, den;
        logic [127:0]          rad, sq, t;
        logic                  ovf;
        a = c.coef_a;
        b = c.coef_b;
        k = c.coef_c;
        ovf = 1'b0;
        r.root_one = '0;
        r.root_two = '0;
        if (a == 0)
        begin
            if (b == 0)
                r.kind = (k == 0) ? KIND_INF : KIND_NONE;
            else
            begin
                r.kind = KIND_LIN;
                r.root_one = clamp_root((-k * 65536) / b, ovf);
                r.root_two = r.root_one;
            end
        end
        else
        begin
            disc = b * b - 4 * a * k;
            den  = 2 * a;
            nb   = -b * 65536;
            if (disc < 0)
                r.kind = KIND_NONE;
            else if (disc == 0)
            begin
                r.kind = KIND_DBL;
                r.root_one = clamp_root(nb / den, ovf);
                r.root_two = r.root_one;
            end
            else
            begin
                rad = disc << 32;
                sq  = '0;
                for (int i = 63; i >= 0; i--)
                begin
                    t = sq | (128'd1 << i);
                    if (t * t <= rad)
                        sq = t;
                end
                s = sq;
                r.kind = KIND_TWO;
                r.root_one = clamp_root((nb + s) / den, ovf);
                r.root_two = clamp_root((nb - s) / den, ovf);
            end
        end
        r.overflow = ovf;
        return r;
    endfunction

    // mismatch report
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    // send one coefficient transfer with random sender gaps
    task automatic send_coefs(input coef_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            coef_valid <= 1'b0;
            @(posedge clk);
        end
        coef_valid <= 1'b1;
        coefs      <= c;
        expected_roots.push_back(solve_roots(c));
        @(posedge clk);
        while (coef_stall)
            @(posedge clk);
    endtask

    // receiver stall and result checking
    always @(posedge clk)
    begin
        root_t want;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_roots.size() == 0)
                begin
                    $display("unexpected result transfer");
                    error_count++;
                end
                else
                begin
                    want = expected_roots.pop_front();
                    if (res.kind != want.kind)
                        report_mismatch("kind", res.kind, want.kind);
                    if (res.root_one != want.root_one)
                        report_mismatch("root_one", res.root_one, want.root_one);
                    if (res.root_two != want.root_two)
                        report_mismatch("root_two", res.root_two, want.root_two);
                    if (res.overflow != want.overflow)
                        report_mismatch("overflow", res.overflow, want.overflow);
                end
            end
            res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((coef_valid && !coef_stall) || (res_valid && !res_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic wait_drained();
        coef_valid <= 1'b0;
        @(posedge clk);
        while (expected_roots.size() != 0)
            @(posedge clk);
    endtask

    function automatic coef_t make_coefs(input int a, input int b, input int c);
        coef_t r;
        r.coef_a = a[15:0];
        r.coef_b = b[15:0];
        r.coef_c = c[15:0];
        return r;
    endfunction

    // random triple: half fully random, the rest linear, degenerate, equal-root, tiny-a or small shapes
    function automatic coef_t random_coefs();
        coef_t r;
        int    sel, p, q, a;
        sel = $urandom_range(9);
        r = coef_t'(48'({$urandom, $urandom}));
        if (sel == 0)
            r.coef_a = '0;
        else if (sel == 1)
        begin
            r.coef_a = '0;
            r.coef_b = '0;
            if ($urandom_range(1)) r.coef_c = '0;
        end
        else if (sel == 2)
        begin
            // double root: a=p*p, b=2*p*q, c=q*q
            p = $urandom_range(1, 100) * ($urandom_range(1) ? 1 : -1);
            q = $urandom_range(0, 100) * ($urandom_range(1) ? 1 : -1);
            r = make_coefs(p * p, 2 * p * q, q * q);
        end
        else if (sel == 3)
        begin
            // tiny a gives large roots, some beyond the root range
            a = $urandom_range(1, 3) * ($urandom_range(1) ? 1 : -1);
            r.coef_a = a[15:0];
        end
        else if (sel == 4)
        begin
            r.coef_a = 16'($urandom_range(0, 511) - 256);
            r.coef_b = 16'($urandom_range(0, 2047) - 1024);
            r.coef_c = 16'($urandom_range(0, 2047) - 1024);
        end
        return r;
    endfunction

    task automatic test_directed();
        send_coefs(make_coefs(0, 0, 0));
        send_coefs(make_coefs(0, 0, 256));
        send_coefs(make_coefs(0, 0, -32768));
        send_coefs(make_coefs(0, 256, -512));
        send_coefs(make_coefs(0, 1, 32767));
        send_coefs(make_coefs(0, 1, -32768));
        send_coefs(make_coefs(0, -32768, 32767));
        send_coefs(make_coefs(256, 0, 256));
        send_coefs(make_coefs(256, -512, 256));
        send_coefs(make_coefs(256, 0, -1024));
        send_coefs(make_coefs(1, 32767, 0));
        send_coefs(make_coefs(1, -32768, 0));
        send_coefs(make_coefs(-1, -32768, 32767));
        send_coefs(make_coefs(-32768, -32768, -32768));
        send_coefs(make_coefs(32767, 32767, 32767));
        send_coefs(make_coefs(32767, -32768, -32768));
        send_coefs(make_coefs(-32768, 32767, 32767));
        send_coefs(make_coefs(1, 0, -32768));
        send_coefs(make_coefs(-1, 2, -1));
        send_coefs(make_coefs(-1, -1, -1));
        wait_drained();
    endtask

    task automatic test_random(input int count, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < count; i++)
            send_coefs(random_coefs());
    endtask

    initial
    begin
        rst_n          = 1'b0;
        coef_valid     = 1'b0;
        coefs          = '0;
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(260, 0, 0);
        test_random(260, 79, 0);
        wait_drained();
        test_random(260, 0, 79);
        test_random(250, 8, 8);
        wait_drained();
        recv_stall_pct = 0;
        repeat (200) @(posedge clk);

        if (error_count == 0 && expected_roots.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
